// ===== rtl/nufp_pkg.sv =====
// Package: word types, job descriptor and header constants of the NAL unit packetiser.
`timescale 1ns / 1ps

package nufp_pkg;

	// Field widths fixed by the interface
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned ULEN_W   = 20;
	localparam int unsigned FILL_W   = 16;
	localparam int unsigned SLOTS    = 4;

	// Configuration register indexes
	localparam logic REG_CODEC = 1'b0;
	localparam logic REG_MAX   = 1'b1;

	// Configuration reset values and limits
	localparam logic [FILL_W-1:0] MAX_RESET   = 16'd1400;
	localparam logic [FILL_W-1:0] MAX_FLOOR   = 16'd8;

	// Header position codes: NAL header bytes still to come in fragment mode
	localparam logic [1:0] HPOS_NONE = 2'd0;
	localparam logic [1:0] HPOS_LAST = 2'd1;
	localparam logic [1:0] HPOS_TWO  = 2'd2;

	// FU header construction
	localparam logic [7:0] H264_IND_KEEP  = 8'hE0;
	localparam logic [7:0] H264_FU_A_TYPE = 8'd28;
	localparam logic [7:0] H264_TYPE_MASK = 8'h1F;
	localparam logic [7:0] H265_IND_KEEP  = 8'h81;
	localparam logic [7:0] H265_FU_TYPE   = 8'd98;
	localparam logic [7:0] H265_TYPE_MASK = 8'h7E;
	localparam logic [7:0] FU_S_BIT       = 8'h80;
	localparam logic [7:0] FU_E_BIT       = 8'h40;

	// Input word
	typedef struct packed {
		logic [BYTE_W-1:0] nal_byte;
		logic              first_of_unit;
		logic [ULEN_W-1:0] unit_length;
	} nufp_in_t;

	// Result word
	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic              packet_end;
		logic              unit_done;
		logic              is_fragment;
		logic              last_of_run;
	} nufp_out_t;

	// Job passed from front to back: one to four bytes, marks on the last one
	typedef struct packed {
		logic [1:0]                   n_m1;
		logic [SLOTS-1:0][BYTE_W-1:0] bytes;
		logic                         is_fragment;
		logic                         packet_end;
		logic                         unit_done;
	} nufp_job_t;

endpackage

// ===== rtl/nufp_front.sv =====
// Front end: configuration registers, unit tracking and job building per input word.
`timescale 1ns / 1ps

module nufp_front #(
	parameter int unsigned LENGTH_BITS = 20
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic                       wr_index,
	input  logic [nufp_pkg::FILL_W-1:0] wr_data,
	input  logic                       in_take,
	input  nufp_pkg::nufp_in_t         in_word,
	output logic                       job_we,
	output nufp_pkg::nufp_job_t        job
);

	localparam int unsigned CW =
		((LENGTH_BITS > nufp_pkg::FILL_W) ? LENGTH_BITS : nufp_pkg::FILL_W) + 1;

	logic                        codec_q;
	logic [nufp_pkg::FILL_W-1:0] max_q;

	logic [LENGTH_BITS-1:0]      rem_q, rem_d, rem_w, rem_dec, len_m;
	logic [nufp_pkg::FILL_W-1:0] fill_q, fill_d, fill_w, fill_base, fill_inc;
	logic [nufp_pkg::FILL_W-1:0] umax_q, umax_w;
	logic                        frag_q, frag_d, frag_w;
	logic [1:0]                  hpos_q, hpos_d, hpos_w;
	logic                        h265_q, h265_w;
	logic [7:0]                  ind_q, ind_d, sec_q, sec_d, fu_q, fu_d;
	logic [7:0]                  b, h264_ind, h264_fu, e_bits;
	logic [1:0]                  hdr;
	logic                        live, rem_zero, pkt_full, has_job;

	// Hold configuration; a write takes effect at the next first byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_q <= 1'b0;
			max_q   <= nufp_pkg::MAX_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				nufp_pkg::REG_CODEC: codec_q <= wr_data[0];
				nufp_pkg::REG_MAX:   max_q   <= wr_data;
				default:             max_q   <= max_q;
			endcase
		end
	end

	assign b        = in_word.nal_byte;
	assign h264_ind = (b & nufp_pkg::H264_IND_KEEP) | nufp_pkg::H264_FU_A_TYPE;
	assign h264_fu  = b & nufp_pkg::H264_TYPE_MASK;

	// Classify the word and build the next state and job
	always_comb begin
		len_m = LENGTH_BITS'(in_word.unit_length);
		live  = 1'b1;
		if (in_word.first_of_unit) begin
			rem_w  = (len_m == '0) ? LENGTH_BITS'(1) : len_m;
			umax_w = (max_q < nufp_pkg::MAX_FLOOR) ? nufp_pkg::MAX_FLOOR : max_q;
			h265_w = codec_q;
			fill_w = '0;
			frag_w = CW'(rem_w) > CW'(umax_w);
			hpos_w = frag_w ? (codec_q ? nufp_pkg::HPOS_TWO : nufp_pkg::HPOS_LAST)
				: nufp_pkg::HPOS_NONE;
		end else begin
			rem_w  = rem_q;
			umax_w = umax_q;
			h265_w = h265_q;
			fill_w = fill_q;
			frag_w = frag_q;
			hpos_w = hpos_q;
			live   = (rem_q != '0);
		end

		rem_dec   = rem_w - LENGTH_BITS'(1);
		rem_zero  = (rem_dec == '0);
		hdr       = h265_w ? 2'd3 : 2'd2;
		e_bits    = ((CW'(hdr) + CW'(rem_w)) <= CW'(umax_w)) ? nufp_pkg::FU_E_BIT : 8'h00;
		fill_base = (fill_w == '0) ? nufp_pkg::FILL_W'(hdr) : fill_w;
		fill_inc  = (frag_w ? fill_base : fill_w) + nufp_pkg::FILL_W'(1);
		pkt_full  = rem_zero || (fill_inc >= umax_w);

		rem_d  = rem_q;
		fill_d = fill_q;
		frag_d = frag_q;
		hpos_d = hpos_q;
		ind_d  = ind_q;
		sec_d  = sec_q;
		fu_d   = fu_q;

		has_job         = 1'b0;
		job.n_m1        = 2'd0;
		job.bytes       = '0;
		job.is_fragment = 1'b0;
		job.packet_end  = 1'b0;
		job.unit_done   = 1'b0;

		if (live) begin
			rem_d  = rem_dec;
			frag_d = frag_w;
			hpos_d = hpos_w;
			if (!frag_w) begin
				// Single packet: pass the byte through
				has_job        = 1'b1;
				job.bytes[0]   = b;
				job.packet_end = pkt_full;
				job.unit_done  = rem_zero;
				fill_d         = pkt_full ? '0 : fill_inc;
			end else if (hpos_w != nufp_pkg::HPOS_NONE) begin
				job.is_fragment = 1'b1;
				job.packet_end  = 1'b0;
				if (!h265_w) begin
					// H.264 header: indicator and FU header with S
					ind_d        = h264_ind;
					fu_d         = h264_fu;
					has_job      = 1'b1;
					job.n_m1     = 2'd1;
					job.bytes[0] = h264_ind;
					job.bytes[1] = nufp_pkg::FU_S_BIT | h264_fu;
					fill_d       = nufp_pkg::FILL_W'(2);
					hpos_d       = nufp_pkg::HPOS_NONE;
				end else if (hpos_w == nufp_pkg::HPOS_TWO) begin
					// H.265 first header byte: save, no result
					ind_d  = (b & nufp_pkg::H265_IND_KEEP) | nufp_pkg::H265_FU_TYPE;
					fu_d   = (b & nufp_pkg::H265_TYPE_MASK) >> 1;
					hpos_d = nufp_pkg::HPOS_LAST;
				end else begin
					// H.265 second header byte: emit all three header bytes
					sec_d        = b;
					has_job      = 1'b1;
					job.n_m1     = 2'd2;
					job.bytes[0] = ind_q;
					job.bytes[1] = b;
					job.bytes[2] = nufp_pkg::FU_S_BIT | fu_q;
					fill_d       = nufp_pkg::FILL_W'(3);
					hpos_d       = nufp_pkg::HPOS_NONE;
				end
			end else begin
				// Fragment body: repeat headers at each packet start
				has_job         = 1'b1;
				job.is_fragment = 1'b1;
				job.packet_end  = pkt_full;
				job.unit_done   = rem_zero;
				if (fill_w != '0) begin
					job.bytes[0] = b;
				end else if (h265_w) begin
					job.n_m1     = 2'd3;
					job.bytes[0] = ind_q;
					job.bytes[1] = sec_q;
					job.bytes[2] = fu_q | e_bits;
					job.bytes[3] = b;
				end else begin
					job.n_m1     = 2'd2;
					job.bytes[0] = ind_q;
					job.bytes[1] = fu_q | e_bits;
					job.bytes[2] = b;
				end
				fill_d = pkt_full ? '0 : fill_inc;
			end
			if (rem_zero) begin
				frag_d = 1'b0;
				hpos_d = nufp_pkg::HPOS_NONE;
			end
		end
	end

	assign job_we = in_take && has_job;

	// Advance unit state on each accepted word of a live unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			fill_q <= '0;
			frag_q <= 1'b0;
			hpos_q <= nufp_pkg::HPOS_NONE;
			ind_q  <= '0;
			sec_q  <= '0;
			fu_q   <= '0;
			h265_q <= 1'b0;
			umax_q <= nufp_pkg::MAX_RESET;
		end else if (in_take && live) begin
			rem_q  <= rem_d;
			fill_q <= fill_d;
			frag_q <= frag_d;
			hpos_q <= hpos_d;
			ind_q  <= ind_d;
			sec_q  <= sec_d;
			fu_q   <= fu_d;
			h265_q <= h265_w;
			umax_q <= umax_w;
		end
	end

endmodule

// ===== rtl/nufp_job_queue.sv =====
// Job queue: short register FIFO that decouples the front end from the serialiser.
`timescale 1ns / 1ps

module nufp_job_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  nufp_pkg::nufp_job_t wr_job,
	output logic                full,
	input  logic                rd_en,
	output nufp_pkg::nufp_job_t rd_job,
	output logic                nonempty
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned NW = $clog2(DEPTH + 1);

	nufp_pkg::nufp_job_t store_q [DEPTH];
	logic [PW-1:0]       wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]       count_q;
	logic                do_wr, do_rd;

	assign full     = (count_q == NW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && nonempty;
	assign rd_job   = store_q[rd_ptr_q];

	// Store the incoming job
	always_ff @(posedge clk) begin
		if (do_wr) begin
			store_q[wr_ptr_q] <= wr_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + NW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

// ===== rtl/nufp_back.sv =====
// Back end: unpacks jobs one byte per cycle into the registered result word while it is empty or popped.
`timescale 1ns / 1ps

module nufp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  nufp_pkg::nufp_job_t head,
	input  logic                head_valid,
	output logic                head_pop,
	input  logic                pop,
	output logic                empty,
	output nufp_pkg::nufp_out_t result
);

	logic                out_v_q;
	nufp_pkg::nufp_out_t out_q;
	logic [1:0]          idx_q;
	logic                load, last;

	assign load     = head_valid && (!out_v_q || pop);
	assign last     = (idx_q == head.n_m1);
	assign head_pop = load && last;
	assign empty    = !out_v_q;
	assign result   = out_q;

	// Load the next byte of the head job into the output register
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.payload_byte <= head.bytes[idx_q];
			out_q.packet_end   <= last && head.packet_end;
			out_q.unit_done    <= last && head.unit_done;
			out_q.is_fragment  <= head.is_fragment;
			out_q.last_of_run  <= last;
		end
	end

	// Track the slot index and the output word's presence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				idx_q   <= last ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/nal_unit_fu_packetizer.sv =====
// Top level: RTP packetiser for H.264/H.265 NAL units with FU fragmentation.
//
// Input words (nal_item) are pushed with push while full is low; the first
// byte of a unit carries first_of_unit and the unit length. Result words
// (payload_item) are offered while empty is low and taken with pop. The
// configuration port (wr_en, wr_index, wr_data) writes codec_select (index 0)
// and max_payload_size (index 1); a new value applies from the next first byte.
// The front end classifies each byte in the cycle it is accepted and queues
// a job of one to four result words if the byte yields any. The serialiser
// puts one word per cycle into the output register while pop keeps up, also
// for payload bytes; a byte's first result passes the job queue, then the output
// register. Header words at a packet start are absorbed by the JOB_DEPTH-entry
// queue; full rises only when that queue is full. While pop is low the output
// word holds and the queue keeps filling. Reset clears the unit state, empties
// the queue and restores codec 0 and a 1400-byte payload size; no clearing pass.
`timescale 1ns / 1ps

module nal_unit_fu_packetizer #(
	parameter int unsigned LENGTH_BITS = 20,
	parameter int unsigned JOB_DEPTH   = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic                        wr_index,
	input  logic [nufp_pkg::FILL_W-1:0] wr_data,
	input  logic                        push,
	output logic                        full,
	input  nufp_pkg::nufp_in_t          nal_item,
	input  logic                        pop,
	output logic                        empty,
	output nufp_pkg::nufp_out_t         payload_item
);

	nufp_pkg::nufp_job_t job, head;
	logic                job_we, head_valid, head_pop, in_take;

	// Accept a word when the queue has room
	assign in_take = push && !full;

	nufp_front #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.in_take  (in_take),
		.in_word  (nal_item),
		.job_we   (job_we),
		.job      (job)
	);

	nufp_job_queue #(
		.DEPTH (JOB_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (job_we),
		.wr_job   (job),
		.full     (full),
		.rd_en    (head_pop),
		.rd_job   (head),
		.nonempty (head_valid)
	);

	nufp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.pop        (pop),
		.empty      (empty),
		.result     (payload_item)
	);

endmodule
